// ----- hdl/pfe_pkg.sv -----
// ----------------------------------------------------------------------------
// pfe_pkg
// shared types and constants of the postfix expression evaluator
// ----------------------------------------------------------------------------
package pfe_pkg;

    localparam int PFE_DATA_W      = 32;
    localparam int PFE_STACK_DEPTH = 64;

    // character codes
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_DIVZERO   = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_mark;
    } in_word_t;

    typedef struct packed {
        logic signed [PFE_DATA_W-1:0] value;
        logic [1:0]                   status;
    } out_word_t;

    // what a stack cell does at a clock edge
    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_LOAD,   // take the word of the neighbor above (push)
        CMD_LIFT    // take the word of the neighbor below (pop)
    } cell_cmd_t;

    typedef enum logic [1:0] {
        OPK_NONE,
        OPK_DIGIT,
        OPK_ARITH,
        OPK_DIV
    } op_kind_t;

    // divider handshake toward the unit
    typedef struct packed {
        logic                  start;
        logic [PFE_DATA_W-1:0] dividend;
        logic [PFE_DATA_W-1:0] divisor;
    } div_req_t;

    // divider reply
    typedef struct packed {
        logic                  done;
        logic [PFE_DATA_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ----- hdl/pfe_cell.sv -----
// ----------------------------------------------------------------------------
// pfe_cell
// one stack entry: holds, takes the word above, or takes the word below
// ----------------------------------------------------------------------------
module pfe_cell
    import pfe_pkg::*;
(
    input  logic                  clk,
    input  cell_cmd_t             cmd,
    input  logic [PFE_DATA_W-1:0] from_above,
    input  logic [PFE_DATA_W-1:0] from_below,
    output logic [PFE_DATA_W-1:0] q
);

    logic [PFE_DATA_W-1:0] data_reg;
    logic [PFE_DATA_W-1:0] data_next;

    always_comb
    begin
        case (cmd)
            CMD_LOAD: data_next = from_above;
            CMD_LIFT: data_next = from_below;
            default:  data_next = data_reg;
        endcase
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

// ----- hdl/pfe_div.sv -----
// ----------------------------------------------------------------------------
// pfe_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pfe_div
    import pfe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(PFE_DATA_W);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [PFE_DATA_W-1:0] rem_reg, rem_next;
    logic [PFE_DATA_W-1:0] quo_reg, quo_next;
    logic [PFE_DATA_W-1:0] dvs_reg, dvs_next;
    logic [PFE_DATA_W:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quo_reg[PFE_DATA_W-1]} - {1'b0, dvs_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[PFE_DATA_W])
            begin
                rem_next = trial[PFE_DATA_W-1:0];
                quo_next = {quo_reg[PFE_DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[PFE_DATA_W-2:0], quo_reg[PFE_DATA_W-1]};
                quo_next = {quo_reg[PFE_DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(PFE_DATA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ----- hdl/postfix_expression_evaluator.sv -----
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// reverse polish evaluator on a shifting stack of cells
// ----------------------------------------------------------------------------
// usage
//   char channel (char_valid / char_stall / char_word): one character per
//   word; a word is taken at an edge with valid high and stall low
//   res channel (res_valid / res_stall / res_word): one word per word that
//   carried end_mark, holding the top of stack and the first error seen
// timing
//   digits, + - and * are taken back to back while char_stall is low; the multiply
//   lands straight in the top cell
//   '/' goes to the divider, which resolves one quotient bit per cycle, and
//   char_stall stays high until the quotient is written to the top cell
//   a result is registered as its last word is taken (as the divider finishes
//   when that word is '/'), into the skid if an unread result still waits
// stall
//   the result register is backed by one skid register, so input keeps
//   flowing while a result waits; char_stall rises only when the skid is
//   full or the divider is busy
// reset
//   rst_n clears stack depth, error status, divider and result valids;
//   stack contents are left as they are and only ever read after a push
// ----------------------------------------------------------------------------
module postfix_expression_evaluator
    import pfe_pkg::*;
#(
    parameter int STACK_DEPTH = PFE_STACK_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      char_valid,
    output logic      char_stall,
    input  in_word_t  char_word,
    output logic      res_valid,
    input  logic      res_stall,
    output out_word_t res_word
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    // stack cells, index 0 is the top of stack
    logic [PFE_DATA_W-1:0] cell_q [STACK_DEPTH];
    cell_cmd_t             cmd_top;
    cell_cmd_t             cmd_rest;
    logic [PFE_DATA_W-1:0] new_top;

    // control state
    logic [CNT_W-1:0] count_reg, count_next;
    logic [1:0]       err_reg, err_next;
    logic             wait_reg, wait_next;     // divide in flight
    logic             pend_end_reg, pend_end_next;
    logic             neg_reg, neg_next;

    // result register and skid
    logic      out_valid_reg, out_valid_next;
    out_word_t out_reg, out_next;
    logic      skid_valid_reg, skid_valid_next;
    out_word_t skid_reg, skid_next;

    logic      char_accept;
    op_kind_t  kind;
    logic      has_two;
    logic      full;
    logic      emit;
    out_word_t emit_word;
    logic [CNT_W-1:0]      count_pre;
    logic [1:0]            err_pre;
    logic [PFE_DATA_W-1:0] arith_res;
    logic [PFE_DATA_W-1:0] lhs;
    logic [PFE_DATA_W-1:0] rhs;
    div_req_t              div_req;
    div_rsp_t              div_rsp;
    logic                  pop_out;

    // ------------------------------------------------------------------
    // chain of cells
    // ------------------------------------------------------------------
    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++)
        begin : g_cell
            logic [PFE_DATA_W-1:0] above_w;
            logic [PFE_DATA_W-1:0] below_w;
            if (gi == 0)
            begin : g_top
                assign above_w = new_top;
            end
            else
            begin : g_mid
                assign above_w = cell_q[gi-1];
            end
            if (gi == STACK_DEPTH - 1)
            begin : g_bot
                assign below_w = '0;
            end
            else
            begin : g_up
                assign below_w = cell_q[gi+1];
            end
            pfe_cell u_cell (
                .clk        (clk),
                .cmd        ((gi == 0) ? cmd_top : cmd_rest),
                .from_above (above_w),
                .from_below (below_w),
                .q          (cell_q[gi])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // divider
    // ------------------------------------------------------------------
    pfe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ------------------------------------------------------------------
    // decode and stack control
    // ------------------------------------------------------------------
    assign char_stall  = wait_reg || skid_valid_reg;
    assign char_accept = char_valid && !char_stall;

    assign rhs     = cell_q[0];
    assign lhs     = cell_q[1];
    assign has_two = count_reg >= CNT_W'(2);
    assign full    = count_reg == CNT_W'(STACK_DEPTH);

    always_comb
    begin
        unique case (char_word.char_code) inside
            CH_PLUS, CH_MINUS, CH_STAR: kind = OPK_ARITH;
            CH_SLASH:                   kind = OPK_DIV;
            [CH_ZERO:CH_NINE]:          kind = OPK_DIGIT;
            default:                    kind = OPK_NONE;
        endcase
    end

    always_comb
    begin
        case (char_word.char_code)
            CH_PLUS:  arith_res = lhs + rhs;
            CH_MINUS: arith_res = lhs - rhs;
            default:  arith_res = lhs * rhs;
        endcase
    end

    always_comb
    begin
        cmd_top       = CMD_HOLD;
        cmd_rest      = CMD_HOLD;
        new_top       = PFE_DATA_W'(char_word.char_code - CH_ZERO);
        count_pre     = count_reg;
        err_pre       = err_reg;
        wait_next     = wait_reg;
        pend_end_next = pend_end_reg;
        neg_next      = neg_reg;
        emit          = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = lhs[PFE_DATA_W-1] ? (~lhs + 1'b1) : lhs;
        div_req.divisor  = rhs[PFE_DATA_W-1] ? (~rhs + 1'b1) : rhs;

        if (div_rsp.done && wait_reg)
        begin
            // quotient replaces the two operands
            cmd_top   = CMD_LOAD;
            cmd_rest  = CMD_LIFT;
            new_top   = neg_reg ? (~div_rsp.quotient + 1'b1) : div_rsp.quotient;
            count_pre = count_reg - 1'b1;
            wait_next = 1'b0;
            emit      = pend_end_reg;
        end
        else if (char_accept)
        begin
            emit = char_word.end_mark;
            case (kind)
                OPK_DIGIT:
                begin
                    if (!full)
                    begin
                        cmd_top   = CMD_LOAD;
                        cmd_rest  = CMD_LOAD;
                        count_pre = count_reg + 1'b1;
                    end
                    else if (err_reg == ST_OK)
                    begin
                        err_pre = ST_OVERFLOW;
                    end
                end
                OPK_ARITH:
                begin
                    if (has_two)
                    begin
                        cmd_top   = CMD_LOAD;
                        cmd_rest  = CMD_LIFT;
                        new_top   = arith_res;
                        count_pre = count_reg - 1'b1;
                    end
                    else if (err_reg == ST_OK)
                    begin
                        err_pre = ST_UNDERFLOW;
                    end
                end
                OPK_DIV:
                begin
                    if (!has_two)
                    begin
                        if (err_reg == ST_OK)
                        begin
                            err_pre = ST_UNDERFLOW;
                        end
                    end
                    else if (rhs == '0)
                    begin
                        if (err_reg == ST_OK)
                        begin
                            err_pre = ST_DIVZERO;
                        end
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        wait_next     = 1'b1;
                        pend_end_next = char_word.end_mark;
                        neg_next      = lhs[PFE_DATA_W-1] ^ rhs[PFE_DATA_W-1];
                        emit          = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // top of stack as it stands after this word
        emit_word.status = err_pre;
        if (count_pre == '0)
        begin
            emit_word.value = '0;
        end
        else if (cmd_top == CMD_LOAD)
        begin
            emit_word.value = $signed(new_top);
        end
        else
        begin
            emit_word.value = $signed(cell_q[0]);
        end

        if (emit)
        begin
            count_next = '0;
            err_next   = ST_OK;
        end
        else
        begin
            count_next = count_pre;
            err_next   = err_pre;
        end
    end

    // ------------------------------------------------------------------
    // result register with skid
    // ------------------------------------------------------------------
    assign pop_out = out_valid_reg && !res_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (pop_out)
        begin
            out_valid_next = 1'b0;
        end
        if (skid_valid_reg)
        begin
            // no new result can arise while the skid is full
            if (pop_out)
            begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (emit)
        begin
            if (!out_valid_reg || pop_out)
            begin
                out_valid_next = 1'b1;
                out_next       = emit_word;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_next       = emit_word;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            err_reg        <= ST_OK;
            wait_reg       <= 1'b0;
            pend_end_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            err_reg        <= err_next;
            wait_reg       <= wait_next;
            pend_end_reg   <= pend_end_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign res_valid = out_valid_reg;
    assign res_word  = out_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_stall_on_div: assert property (@(posedge clk) disable iff (!rst_n)
        wait_reg |-> char_stall)
        else $error("input taken during a divide");

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid full with empty result register");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (char_accept && char_word.end_mark && !div_req.start)
            |=> (count_reg == '0 && err_reg == ST_OK))
        else $error("stack not cleared after end of expression");

    a_div_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |=> wait_reg)
        else $error("divide started without holding input");

endmodule
